/* hdl/hmbs_pkg.sv */
`default_nettype none

package hmbs_pkg;

	// Grid geometry and fixed point format
	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 256;
	localparam int FRAC_BITS = 8;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int CELL_W = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int DEPTH  = MAX_COLS * MAX_ROWS;

	// Field widths
	localparam int HEIGHT_W = 16;
	localparam int POS_W    = 24;
	localparam int SIZE_W   = 9;
	localparam int SCALE_W  = 16;

	// Fraction carries one extra bit: it reaches one on the last column or row
	localparam int FRAC_W = FRAC_BITS + 1;
	// Corner weight wx*wz, at most one squared
	localparam int WGT_W  = 2 * FRAC_BITS + 1;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_LENGTH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE   = CFG_IDX_W'(2);

	localparam logic [SIZE_W-1:0]  RST_GRID_WIDTH  = SIZE_W'(256);
	localparam logic [SIZE_W-1:0]  RST_GRID_LENGTH = SIZE_W'(256);
	localparam logic [SCALE_W-1:0] RST_INV_SCALE   = SCALE_W'(256);

	// Action codes
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0]  grid_width;
		logic [SIZE_W-1:0]  grid_length;
		logic [SCALE_W-1:0] inv_scale;
	} hmbs_cfg_t;

	// Command passed from front to back
	typedef struct packed {
		logic                is_write;
		logic [COL_W-1:0]    col;
		logic [ROW_W-1:0]    row;
		logic [FRAC_W-1:0]   fx;
		logic [FRAC_W-1:0]   fz;
		logic [HEIGHT_W-1:0] data;
	} hmbs_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} hmbs_state_t;

endpackage

`default_nettype wire

/* hdl/hmbs_if.sv */
`default_nettype none

// Request channel: height writes and sample positions
interface hmbs_req_if;
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic [hmbs_pkg::COL_W-1:0]         col;
	logic [hmbs_pkg::ROW_W-1:0]         row;
	logic signed [hmbs_pkg::HEIGHT_W-1:0] height_value;
	logic signed [hmbs_pkg::POS_W-1:0]  pos_x;
	logic signed [hmbs_pkg::POS_W-1:0]  pos_z;

	modport source (output valid, action, col, row, height_value, pos_x, pos_z, input ready);
	modport sink   (input valid, action, col, row, height_value, pos_x, pos_z, output ready);
endinterface

// Response channel: interpolated heights
interface hmbs_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hmbs_pkg::HEIGHT_W-1:0] height;

	modport source (output valid, height, input ready);
	modport sink   (input valid, height, output ready);
endinterface

`default_nettype wire

/* hdl/hmbs_ram.sv */
`default_nettype none

module hmbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/hmbs_front.sv */
`default_nettype none

module hmbs_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire hmbs_pkg::hmbs_cfg_t cfg,
	hmbs_req_if.sink                 req,
	output      logic                push_valid,
	input  wire logic                push_ready,
	output      hmbs_pkg::hmbs_cmd_t push_data
);

	// Q16.8 position times Q8.8 scale gives sixteen fraction bits
	localparam int PROD_W = hmbs_pkg::POS_W + hmbs_pkg::SCALE_W + 1;
	localparam int SHIFT  = 2 * 8 - hmbs_pkg::FRAC_BITS;
	localparam int CRD_W  = hmbs_pkg::CELL_W + hmbs_pkg::FRAC_BITS;
	localparam int ONE    = 1 << hmbs_pkg::FRAC_BITS;

	function automatic logic [hmbs_pkg::SIZE_W-1:0] clamp_size(
		input logic [hmbs_pkg::SIZE_W-1:0] v,
		input logic [hmbs_pkg::SIZE_W-1:0] hi
	);
		logic [hmbs_pkg::SIZE_W-1:0] r;
		if (v < hmbs_pkg::SIZE_W'(2)) begin
			r = hmbs_pkg::SIZE_W'(2);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Clamp a scaled coordinate to [0, n-1] and split it into cell and fraction
	function automatic logic [hmbs_pkg::CELL_W+hmbs_pkg::FRAC_W-1:0] split_coord(
		input logic signed [PROD_W-1:0]   p,
		input logic [hmbs_pkg::SIZE_W-1:0] n
	);
		logic [PROD_W-1:0]                 c;
		logic [CRD_W-1:0]                  lim;
		logic [CRD_W-1:0]                  crd;
		logic [hmbs_pkg::SIZE_W-1:0]       nm1;
		logic [hmbs_pkg::CELL_W-1:0]       cidx;
		logic [hmbs_pkg::FRAC_W-1:0]       frac;
		nm1 = n - hmbs_pkg::SIZE_W'(1);
		lim = {nm1[hmbs_pkg::CELL_W-1:0], hmbs_pkg::FRAC_BITS'(0)};
		c   = $unsigned(p) >> SHIFT;
		if (p < 0) begin
			crd = '0;
		end else if (c > PROD_W'(lim)) begin
			crd = lim;
		end else begin
			crd = c[CRD_W-1:0];
		end
		cidx = crd[CRD_W-1:hmbs_pkg::FRAC_BITS];
		frac = {1'b0, crd[hmbs_pkg::FRAC_BITS-1:0]};
		// last column or row: step back one cell, fraction becomes one
		if (hmbs_pkg::SIZE_W'(cidx) == nm1) begin
			cidx = cidx - hmbs_pkg::CELL_W'(1);
			frac = frac + hmbs_pkg::FRAC_W'(ONE);
		end
		return {cidx, frac};
	endfunction

	logic                                  v_s1;
	logic                                  is_write_s1;
	logic [hmbs_pkg::COL_W-1:0]            col_s1;
	logic [hmbs_pkg::ROW_W-1:0]            row_s1;
	logic [hmbs_pkg::HEIGHT_W-1:0]         data_s1;
	logic signed [PROD_W-1:0]              px_s1;
	logic signed [PROD_W-1:0]              pz_s1;
	logic                                  in_fire;
	logic [hmbs_pkg::SIZE_W-1:0]           w_eff;
	logic [hmbs_pkg::SIZE_W-1:0]           l_eff;
	logic [hmbs_pkg::CELL_W+hmbs_pkg::FRAC_W-1:0] xs;
	logic [hmbs_pkg::CELL_W+hmbs_pkg::FRAC_W-1:0] zs;

	assign req.ready = !v_s1 || push_ready;
	assign in_fire   = req.valid && req.ready;

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_fire) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage 1 payload: scale multiply
	always_ff @(posedge clk) begin
		if (in_fire) begin
			is_write_s1 <= (req.action == hmbs_pkg::ACT_WRITE);
			col_s1      <= req.col;
			row_s1      <= req.row;
			data_s1     <= req.height_value;
			px_s1       <= PROD_W'(req.pos_x) * PROD_W'($signed({1'b0, cfg.inv_scale}));
			pz_s1       <= PROD_W'(req.pos_z) * PROD_W'($signed({1'b0, cfg.inv_scale}));
		end
	end

	// Clamp, cell pick, build command
	assign w_eff = clamp_size(cfg.grid_width, hmbs_pkg::SIZE_W'(hmbs_pkg::MAX_COLS));
	assign l_eff = clamp_size(cfg.grid_length, hmbs_pkg::SIZE_W'(hmbs_pkg::MAX_ROWS));
	assign xs    = split_coord(px_s1, w_eff);
	assign zs    = split_coord(pz_s1, l_eff);

	always_comb begin
		push_data          = '0;
		push_data.is_write = is_write_s1;
		push_data.data     = data_s1;
		if (is_write_s1) begin
			push_data.col = col_s1;
			push_data.row = row_s1;
		end else begin
			push_data.col = xs[hmbs_pkg::FRAC_W +: hmbs_pkg::COL_W];
			push_data.fx  = xs[hmbs_pkg::FRAC_W-1:0];
			push_data.row = zs[hmbs_pkg::FRAC_W +: hmbs_pkg::ROW_W];
			push_data.fz  = zs[hmbs_pkg::FRAC_W-1:0];
		end
	end

	assign push_valid = v_s1;

endmodule

`default_nettype wire

/* hdl/hmbs_queue.sv */
`default_nettype none

module hmbs_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output      logic                push_ready,
	input  wire hmbs_pkg::hmbs_cmd_t push_data,
	output      logic                pop_valid,
	input  wire logic                pop_ready,
	output      hmbs_pkg::hmbs_cmd_t pop_data
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);

	hmbs_pkg::hmbs_cmd_t mem_q [QDEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W:0]      count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != (PTR_W+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* hdl/hmbs_back.sv */
`default_nettype none

module hmbs_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pop_valid,
	output      logic                pop_ready,
	input  wire hmbs_pkg::hmbs_cmd_t pop_data,
	hmbs_rsp_if.source               rsp
);

	localparam int ONE       = 1 << hmbs_pkg::FRAC_BITS;
	localparam int PRD_W     = hmbs_pkg::HEIGHT_W + hmbs_pkg::WGT_W + 1;
	localparam int ACC_W     = PRD_W + 1;
	localparam int MUL_W     = 2 * hmbs_pkg::FRAC_W;
	localparam int STEP_W    = 3;
	localparam int CORNERS   = 4;
	// issue four reads, then drain the weight and product registers into the accumulator
	localparam int LAST_STEP = CORNERS + 1;

	hmbs_pkg::hmbs_state_t         state_q;
	hmbs_pkg::hmbs_state_t         state_d;
	logic [STEP_W-1:0]             step_q;
	logic [STEP_W-1:0]             step_d;
	hmbs_pkg::hmbs_cmd_t           cmd_q;
	logic                          take_cmd;
	logic                          issue;
	logic                          load_out;
	logic                          ram_en;
	logic                          ram_we;
	logic [hmbs_pkg::ADDR_W-1:0]   ram_addr;
	logic [hmbs_pkg::HEIGHT_W-1:0] ram_rdata;
	logic [hmbs_pkg::COL_W-1:0]    corner_col;
	logic [hmbs_pkg::ROW_W-1:0]    corner_row;
	logic [hmbs_pkg::FRAC_W-1:0]   wx;
	logic [hmbs_pkg::FRAC_W-1:0]   wz;
	logic [MUL_W-1:0]              wgt;
	logic                          v_s1;
	logic [hmbs_pkg::WGT_W-1:0]    wgt_s1;
	logic                          v_s2;
	logic signed [PRD_W-1:0]       prod_s2;
	logic signed [ACC_W-1:0]       acc_q;
	logic signed [ACC_W-1:0]       rounded;
	logic                          out_valid_q;
	logic [hmbs_pkg::HEIGHT_W-1:0] height_q;

	// Corner select: bit 1 picks the next column, bit 0 the next row
	assign corner_col = cmd_q.col + hmbs_pkg::COL_W'(step_q[1]);
	assign corner_row = cmd_q.row + hmbs_pkg::ROW_W'(step_q[0]);
	assign wx  = step_q[1] ? cmd_q.fx : hmbs_pkg::FRAC_W'(ONE) - cmd_q.fx;
	assign wz  = step_q[0] ? cmd_q.fz : hmbs_pkg::FRAC_W'(ONE) - cmd_q.fz;
	assign wgt = MUL_W'(wx) * MUL_W'(wz);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmbs_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Next state, memory port and handshake control
	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		pop_ready = 1'b0;
		take_cmd  = 1'b0;
		issue     = 1'b0;
		load_out  = 1'b0;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = {corner_row, corner_col};
		unique case (state_q)
			hmbs_pkg::ST_IDLE: begin
				if (pop_valid) begin
					pop_ready = 1'b1;
					if (pop_data.is_write) begin
						ram_en   = 1'b1;
						ram_we   = 1'b1;
						ram_addr = {pop_data.row, pop_data.col};
					end else begin
						take_cmd = 1'b1;
						step_d   = '0;
						state_d  = hmbs_pkg::ST_RUN;
					end
				end
			end
			hmbs_pkg::ST_RUN: begin
				if (step_q < STEP_W'(CORNERS)) begin
					issue  = 1'b1;
					ram_en = 1'b1;
				end
				if (step_q == STEP_W'(LAST_STEP)) begin
					state_d = hmbs_pkg::ST_FIN;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			hmbs_pkg::ST_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = hmbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hmbs_pkg::ST_IDLE;
			end
		endcase
	end

	hmbs_ram #(
		.WIDTH(hmbs_pkg::HEIGHT_W),
		.DEPTH(hmbs_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(pop_data.data),
		.rdata(ram_rdata)
	);

	// Blend pipeline valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Weight, product, accumulate
	always_ff @(posedge clk) begin
		if (take_cmd) begin
			cmd_q <= pop_data;
		end
		wgt_s1  <= wgt[hmbs_pkg::WGT_W-1:0];
		prod_s2 <= PRD_W'($signed(ram_rdata)) * PRD_W'($signed({1'b0, wgt_s1}));
		if (take_cmd) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (load_out) begin
			height_q <= rounded[2*hmbs_pkg::FRAC_BITS +: hmbs_pkg::HEIGHT_W];
		end
	end

	// Round half up, then floor shift
	assign rounded = acc_q + (ACC_W'(1) <<< (2*hmbs_pkg::FRAC_BITS - 1));

	assign rsp.valid  = out_valid_q;
	assign rsp.height = height_q;

endmodule

`default_nettype wire

/* hdl/heightmap_bilinear_sampler_core.sv */
`default_nettype none

// Heightmap bilinear sampler. Holds a 256 x 256 grid of signed Q8.8 heights in
// a single-port memory; a write transaction (action 0) stores one height at
// (col, row) and returns nothing, a sample transaction (action 1) scales the
// Q16.8 position by inv_scale, clamps it to the grid in use and returns the
// bilinear blend of the four corner heights, rounded half up to Q8.8. The front
// end multiplies and clamps in one registered stage and hands commands to a
// two-entry queue; the back end owns the memory port. A write is stored
// straight from the idle state. A sample takes the command, issues four
// memory reads (one per corner on the single port), drains the weight/multiply
// pipeline and then loads the result register from the accumulator. Results
// leave through an output register, so the next command is started while a
// result waits. Heights are undefined until written; sample only written cells.
// Configuration: cfg_idx 0 grid_width, 1 grid_length, 2 inv_scale; write only
// while no transaction is in flight.
module heightmap_bilinear_sampler_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [hmbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [hmbs_pkg::CFG_DATA_W-1:0] cfg_data,
	hmbs_req_if.sink                             req,
	hmbs_rsp_if.source                           rsp
);

	logic [hmbs_pkg::SIZE_W-1:0]  grid_width_q;
	logic [hmbs_pkg::SIZE_W-1:0]  grid_length_q;
	logic [hmbs_pkg::SCALE_W-1:0] inv_scale_q;
	hmbs_pkg::hmbs_cfg_t          cfg;
	logic                         push_valid;
	logic                         push_ready;
	hmbs_pkg::hmbs_cmd_t          push_data;
	logic                         pop_valid;
	logic                         pop_ready;
	hmbs_pkg::hmbs_cmd_t          pop_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hmbs_pkg::RST_GRID_WIDTH;
			grid_length_q <= hmbs_pkg::RST_GRID_LENGTH;
			inv_scale_q   <= hmbs_pkg::RST_INV_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				hmbs_pkg::REG_GRID_WIDTH:  grid_width_q  <= cfg_data[hmbs_pkg::SIZE_W-1:0];
				hmbs_pkg::REG_GRID_LENGTH: grid_length_q <= cfg_data[hmbs_pkg::SIZE_W-1:0];
				hmbs_pkg::REG_INV_SCALE:   inv_scale_q   <= cfg_data[hmbs_pkg::SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.grid_width  = grid_width_q;
	assign cfg.grid_length = grid_length_q;
	assign cfg.inv_scale   = inv_scale_q;

	hmbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	hmbs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	hmbs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

/* hdl/hmbs_checker.sv */
`default_nettype none

module hmbs_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          req_action,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [hmbs_pkg::HEIGHT_W-1:0] rsp_height
);

	logic seen_sample_q;

	// Remember that some sample transaction has gone in since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_sample_q <= 1'b0;
		end else if (req_valid && req_ready && req_action == hmbs_pkg::ACT_SAMPLE) begin
			seen_sample_q <= 1'b1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_height))
		else $error("response height changed while stalled");

	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("response valid during reset");

	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> seen_sample_q)
		else $error("response without any sample transaction");

endmodule

bind heightmap_bilinear_sampler_core hmbs_checker u_hmbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_action(req.action),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_height(rsp.height)
);

`default_nettype wire

/* tb/heightmap_bilinear_sampler_core_tb.sv */
`default_nettype none

module heightmap_bilinear_sampler_core_tb;
	import hmbs_pkg::*;

	// One request item as seen on the request channel
	typedef struct packed {
		logic                action;
		logic [COL_W-1:0]    col;
		logic [ROW_W-1:0]    row;
		logic [HEIGHT_W-1:0] height_value;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_z;
	} hm_item_t;

	typedef enum logic [1:0] {
		CHK_OK,
		CHK_ORPHAN,
		CHK_WRONG
	} chk_t;

	// Mirror of the height store and registers; predicts each sampled height
	class hm_scoreboard;
		logic [SIZE_W-1:0]   grid_cols_reg;
		logic [SIZE_W-1:0]   grid_rows_reg;
		logic [SCALE_W-1:0]  inv_scale_reg;
		logic [HEIGHT_W-1:0] heights [DEPTH];
		logic [HEIGHT_W-1:0] heights_due [$];

		function new();
			grid_cols_reg = RST_GRID_WIDTH;
			grid_rows_reg = RST_GRID_LENGTH;
			inv_scale_reg = RST_INV_SCALE;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_GRID_WIDTH: begin
				grid_cols_reg = data[SIZE_W-1:0];
			end
			REG_GRID_LENGTH: begin
				grid_rows_reg = data[SIZE_W-1:0];
			end
			REG_INV_SCALE: begin
				inv_scale_reg = data[SCALE_W-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		function int clamp_dim(logic [SIZE_W-1:0] v, int hi);
			if (v < 2)
				return 2;
			if (int'(v) > hi)
				return hi;
			return int'(v);
		endfunction

		function int cols_in_use();
			return clamp_dim(grid_cols_reg, MAX_COLS);
		endfunction

		function int rows_in_use();
			return clamp_dim(grid_rows_reg, MAX_ROWS);
		endfunction

		// Q16.8 position times Q8.8 scale is Q.16; keep FRAC_BITS, clamp to [0, n-1]
		function longint grid_coord(logic [POS_W-1:0] pos, int n);
			longint p;
			longint lim;
			p = longint'($signed(pos)) * longint'(inv_scale_reg);
			if (p < 0)
				return 0;
			p = p >>> (16 - FRAC_BITS);
			lim = longint'(n - 1) << FRAC_BITS;
			return (p > lim) ? lim : p;
		endfunction

		// Cell and fraction of a position; last column/row steps back one cell
		function void locate(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz,
				output int cx, output int cz, output int fx, output int fz);
			longint x;
			longint z;
			int w;
			int l;
			w = cols_in_use();
			l = rows_in_use();
			x = grid_coord(px, w);
			z = grid_coord(pz, l);
			cx = int'(x >> FRAC_BITS);
			if (cx == w - 1)
				cx--;
			cz = int'(z >> FRAC_BITS);
			if (cz == l - 1)
				cz--;
			fx = int'(x - (longint'(cx) << FRAC_BITS));
			fz = int'(z - (longint'(cz) << FRAC_BITS));
		endfunction

		function longint corner(int c, int r);
			return longint'($signed(heights[r * MAX_COLS + c]));
		endfunction

		function void note_input(hm_item_t it);
			int cx;
			int cz;
			int fx;
			int fz;
			longint one;
			longint acc;
			if (it.action == ACT_WRITE) begin
				heights[int'(it.row) * MAX_COLS + int'(it.col)] = it.height_value;
			end else begin
				locate(it.pos_x, it.pos_z, cx, cz, fx, fz);
				one = longint'(1) << FRAC_BITS;
				acc = (one - fx) * ((one - fz) * corner(cx, cz) + fz * corner(cx, cz + 1))
					+ fx * ((one - fz) * corner(cx + 1, cz) + fz * corner(cx + 1, cz + 1));
				// round half up, floor shift back to Q8.8
				acc += longint'(1) << (2 * FRAC_BITS - 1);
				acc = acc >>> (2 * FRAC_BITS);
				heights_due.push_back(acc[HEIGHT_W-1:0]);
			end
		endfunction

		function chk_t check(input logic [HEIGHT_W-1:0] got, output logic [HEIGHT_W-1:0] want);
			if (heights_due.size() == 0) begin
				want = '0;
				return CHK_ORPHAN;
			end
			want = heights_due.pop_front();
			return (got === want) ? CHK_OK : CHK_WRONG;
		endfunction

		function int pending();
			return heights_due.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	hmbs_req_if req_ch ();
	hmbs_rsp_if rsp_ch ();

	hm_scoreboard sb = new();
	bit           height_known [DEPTH];
	bit           calm_tail;
	int           mismatches;
	int           items_sent;

	heightmap_bilinear_sampler_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("%0t: %s", $time, msg);
	endtask

	// Result side: random ready stalls, compare every returned height
	initial begin
		int stall_left;
		logic [HEIGHT_W-1:0] want;
		chk_t verdict;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				verdict = sb.check(rsp_ch.height, want);
				if (verdict == CHK_ORPHAN)
					flag_mismatch($sformatf("unexpected result, height %0d",
						$signed(rsp_ch.height)));
				else if (verdict == CHK_WRONG)
					flag_mismatch($sformatf("height %0d, expected %0d",
						$signed(rsp_ch.height), $signed(want)));
			end
			if (stall_left > 0)
				stall_left--;
			else if (!calm_tail && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 11);
			rsp_ch.ready <= (stall_left == 0);
		end
	end

	// Present one request and hold it until the transaction goes through
	task automatic send_item(input hm_item_t it);
		int gap;
		if (!calm_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.action       <= it.action;
		req_ch.col          <= it.col;
		req_ch.row          <= it.row;
		req_ch.height_value <= it.height_value;
		req_ch.pos_x        <= it.pos_x;
		req_ch.pos_z        <= it.pos_z;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_input(it);
		items_sent++;
	endtask

	function automatic logic [HEIGHT_W-1:0] rand_height();
		case ($urandom_range(0, 9))
		0: return 16'h7FFF;
		1: return 16'h8000;
		default: return HEIGHT_W'($urandom);
		endcase
	endfunction

	// Mostly positions near the grid in use, sometimes anywhere
	function automatic logic [POS_W-1:0] rand_pos(int n);
		longint span;
		longint v;
		if ($urandom_range(0, 3) == 0)
			return POS_W'($urandom);
		if (sb.inv_scale_reg == 0)
			span = 4096;
		else
			span = (longint'(n) << 16) / longint'(sb.inv_scale_reg);
		if (span > 8388607)
			span = 8388607;
		if (span < 16)
			span = 16;
		v = longint'($urandom_range(0, int'(span + span / 4))) - span / 8;
		if (v > 8388607)
			v = 8388607;
		return v[POS_W-1:0];
	endfunction

	task automatic write_height(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
			input logic [HEIGHT_W-1:0] hv);
		hm_item_t it;
		it.action       = ACT_WRITE;
		it.col          = col;
		it.row          = row;
		it.height_value = hv;
		it.pos_x        = POS_W'($urandom);
		it.pos_z        = POS_W'($urandom);
		height_known[int'(row) * MAX_COLS + int'(col)] = 1'b1;
		send_item(it);
	endtask

	// Fill any unwritten corner of the cell first, then sample
	task automatic sample_at(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
		hm_item_t it;
		int cx;
		int cz;
		int fx;
		int fz;
		sb.locate(px, pz, cx, cz, fx, fz);
		for (int r = cz; r <= cz + 1; r++)
			for (int c = cx; c <= cx + 1; c++)
				if (!height_known[r * MAX_COLS + c])
					write_height(COL_W'(c), ROW_W'(r), rand_height());
		it.action       = ACT_SAMPLE;
		it.col          = COL_W'($urandom);
		it.row          = ROW_W'($urandom);
		it.height_value = HEIGHT_W'($urandom);
		it.pos_x        = px;
		it.pos_z        = pz;
		send_item(it);
	endtask

	task automatic run_random(input int budget);
		int start;
		start = items_sent;
		while (items_sent - start < budget) begin
			if ($urandom_range(0, 3) == 0)
				write_height(COL_W'($urandom), ROW_W'($urandom), rand_height());
			else
				sample_at(rand_pos(sb.cols_in_use()), rand_pos(sb.rows_in_use()));
		end
	endtask

	// Stop requests, wait out results, then let write transactions finish
	task automatic settle(input int limit);
		int waited;
		req_ch.valid <= 1'b0;
		waited = 0;
		while (sb.pending() > 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
		repeat (24) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Grid sizes carry random upper bits; only the low SIZE_W bits count
	task automatic set_config(input int w, input int l, input int s);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom);
		d[SIZE_W-1:0] = SIZE_W'(w);
		cfg_write(REG_GRID_WIDTH, d);
		d = CFG_DATA_W'($urandom);
		d[SIZE_W-1:0] = SIZE_W'(l);
		cfg_write(REG_GRID_LENGTH, d);
		cfg_write(REG_INV_SCALE, CFG_DATA_W'(s));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Reset settings: grid coordinate equals position, full 256 x 256 grid
	task automatic directed_items();
		write_height(8'd0, 8'd0, 16'h7FFF);
		write_height(8'd1, 8'd0, 16'h8000);
		write_height(8'd0, 8'd1, 16'h8000);
		write_height(8'd1, 8'd1, 16'h7FFF);
		write_height(8'd254, 8'd254, 16'h0001);
		write_height(8'd255, 8'd254, 16'hFFFF);
		write_height(8'd254, 8'd255, 16'h7FFF);
		write_height(8'd255, 8'd255, 16'h8000);
		sample_at(24'd0, 24'd0);
		sample_at(24'd128, 24'd128);
		sample_at(24'd1, 24'd255);
		// negative positions clamp to the first cell
		sample_at(24'h800000, 24'h800000);
		// far positions clamp to the last cell, fraction one
		sample_at(24'h7FFFFF, 24'h7FFFFF);
		sample_at(24'h7FFFFF, 24'hFFFFFF);
		// on and near the last grid line
		sample_at(24'd65280, 24'd65280);
		sample_at(24'd65279, 24'd65152);
	endtask

	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_idx             <= REG_GRID_WIDTH;
		cfg_data            <= '0;
		req_ch.valid        <= 1'b0;
		req_ch.action       <= ACT_WRITE;
		req_ch.col          <= '0;
		req_ch.row          <= '0;
		req_ch.height_value <= '0;
		req_ch.pos_x        <= '0;
		req_ch.pos_z        <= '0;
		calm_tail = 1'b0;
		mismatches = 0;
		items_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		run_random(130);

		// smallest grid
		settle(20000);
		set_config(2, 2, 256);
		run_random(110);

		// sizes below the minimum, zero scale: everything lands on cell (0, 0)
		settle(20000);
		set_config(0, 1, 0);
		run_random(60);

		// sizes above the maximum, largest scale
		settle(20000);
		set_config(511, 300, 65535);
		run_random(110);

		// smallest nonzero scale
		settle(20000);
		set_config(16, 9, 1);
		run_random(110);

		repeat (3) begin
			settle(20000);
			set_config($urandom_range(2, MAX_COLS), $urandom_range(2, MAX_ROWS),
				$urandom_range(1, 65535));
			run_random(90);
		end

		// no idling on either side for the tail
		settle(20000);
		calm_tail = 1'b1;
		set_config(256, 256, 384);
		run_random(240);

		settle(20000);
		if (sb.pending() > 0)
			flag_mismatch($sformatf("%0d expected heights never arrived", sb.pending()));
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#6000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
